[design/ffha_pkg.sv]
package ffha_pkg;
  localparam int unsigned MaxFree   = 16;
  localparam int unsigned MaxUsed   = 32;
  localparam int unsigned HdrBytes  = 16;
  localparam int unsigned FreeIdxW  = $clog2(MaxFree);
  localparam int unsigned FreeCntW  = $clog2(MaxFree + 1);
  localparam int unsigned UsedIdxW  = $clog2(MaxUsed);
  localparam int unsigned UsedCntW  = $clog2(MaxUsed + 1);
  localparam logic [31:0] ResetBase = 32'h1000_0000;
  localparam logic [31:0] ResetBytes = 32'h1000_0000;
  localparam logic [31:0] AlignMask = 32'h0000_0007;

  localparam logic [0:0] CfgBase  = 1'b0;
  localparam logic [0:0] CfgBytes = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StUnknown = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_FSCAN, S_USCAN, S_ACOMMIT, S_LOOKUP, S_PSCAN,
    S_FCOMMIT, S_SHIFT, S_DONE
  } state_e;

  typedef struct packed {
    logic start;      // latch request, reset counters
    logic fstep;      // advance free index
    logic ustep;      // advance used index
    logic acommit;    // apply allocation
    logic fcommit;    // apply free merge (single entry update)
    logic shstep;     // one step of table shift
    logic finish;     // present result
  } cmd_t;

  typedef struct packed {
    logic hold;        // region being written or tables being rebuilt
    logic is_free;
    logic bad;         // early status 1
    logic fend;        // free scan finished
    logic fhit;        // current free entry fits / is after block
    logic uend;
    logic uhit;        // current used entry matches target
    logic need_shift;  // commit requires shifting
    logic shift_done;
    logic full;        // free table full for insert
  } status_t;
endpackage

[design/ffha_if.sv]
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] request_bytes;
  logic [31:0] block_address;
  modport source(output valid, kind, request_bytes, block_address, input ready);
  modport sink(input valid, kind, request_bytes, block_address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [1:0]  status;
  logic [31:0] bytes_free;
  modport source(output valid, granted_address, status, bytes_free, input ready);
  modport sink(input valid, granted_address, status, bytes_free, output ready);
endinterface

[design/ffha_ctrl.sv]
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  input  status_t sts_i,
  output cmd_t    cmd_o,
  output state_e  state_o
);
  state_e state_q, state_d;
  logic   rsp_q, rsp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rsp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rsp_q   <= rsp_d;
    end
  end

  // A new request is taken only once any waiting result leaves the output register,
  // and never while the tables are being rebuilt.
  assign req_ready_o = (state_q == S_IDLE) && !sts_i.hold && (!rsp_q || rsp_ready_i);
  assign rsp_valid_o = rsp_q;
  assign state_o     = state_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (req_valid_i && req_ready_o) state_d = S_LOOKUP;
      S_LOOKUP:  begin
        if (sts_i.is_free) state_d = S_USCAN;
        else if (sts_i.bad) state_d = S_DONE;
        else state_d = S_FSCAN;
      end
      S_FSCAN:   begin
        if (sts_i.is_free) begin
          if (sts_i.fhit || sts_i.fend) state_d = S_FCOMMIT;
        end else if (sts_i.fend) state_d = S_DONE;
        else if (sts_i.fhit) state_d = S_USCAN;
      end
      S_USCAN:   begin
        if (sts_i.uend) state_d = S_DONE;
        else if (sts_i.uhit) state_d = sts_i.is_free ? S_FSCAN : S_ACOMMIT;
      end
      S_ACOMMIT: state_d = sts_i.need_shift ? S_SHIFT : S_DONE;
      S_FCOMMIT: begin
        if (sts_i.full) state_d = S_DONE;
        else state_d = sts_i.need_shift ? S_SHIFT : S_DONE;
      end
      S_SHIFT:   if (sts_i.shift_done) state_d = S_DONE;
      S_PSCAN:   state_d = S_DONE;
      S_DONE:    if (!rsp_q || rsp_ready_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    rsp_d = rsp_q && !rsp_ready_i;
    case (state_q)
      S_IDLE:    cmd_o.start = req_valid_i && req_ready_o;
      S_FSCAN:   cmd_o.fstep = 1'b1;
      S_USCAN:   cmd_o.ustep = 1'b1;
      S_ACOMMIT: cmd_o.acommit = 1'b1;
      S_FCOMMIT: cmd_o.fcommit = 1'b1;
      S_SHIFT:   cmd_o.shstep = 1'b1;
      S_DONE:    begin
        if (!rsp_q || rsp_ready_i) begin
          cmd_o.finish = 1'b1;
          rsp_d = 1'b1;
        end
      end
      default:   cmd_o = '0;
    endcase
  end
endmodule

[design/ffha_dp.sv]
module ffha_dp
  import ffha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_idx_ok_i,
  input  logic [31:0] cfg_data_i,
  input  logic        kind_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] block_address_i,
  input  cmd_t        cmd_i,
  input  state_e      state_i,
  output status_t     sts_o,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o,
  output logic [31:0] bytes_free_o
);
  logic [31:0] base_q, bytes_q;
  logic [31:0] fst_q [MaxFree];
  logic [31:0] fsz_q [MaxFree];
  logic [FreeCntW-1:0] fcnt_q;
  logic [31:0] ust_q [MaxUsed];
  logic [31:0] usz_q [MaxUsed];
  logic [MaxUsed-1:0] uval_q;
  logic [31:0] rem_q;
  logic        init_q;

  logic        kind_q;
  logic [32:0] total_q;
  logic [31:0] addr_q;
  logic [FreeCntW-1:0] fi_q;
  logic [UsedCntW-1:0] ui_q;
  logic [1:0]  st_q;
  logic [31:0] gr_q;
  logic        ins_q;   // shift direction: insert or remove
  logic [FreeCntW-1:0] sh_q;
  logic [31:0] bs_q, bz_q;

  logic [31:0] rsp_gr_q, rsp_bf_q;
  logic [1:0]  rsp_st_q;

  // init geometry
  logic [32:0] a_start, a_end, a_mark;
  logic        a_ok;
  always_comb begin
    a_start = ({1'b0, base_q} + 33'd7) & ~{1'b0, AlignMask};
    a_end   = {1'b0, base_q} + {1'b0, bytes_q};
    if (a_end > 33'h1_0000_0000) a_end = 33'h1_0000_0000;
    a_mark  = (a_end - 33'(HdrBytes)) & ~{1'b0, AlignMask};
    a_ok    = (a_end >= a_start + 33'(HdrBytes)) && (a_mark > a_start);
  end

  logic [FreeIdxW-1:0] fi, fim1;
  logic [UsedIdxW-1:0] ui;
  logic                fin;
  assign fi   = fi_q[FreeIdxW-1:0];
  assign fim1 = fi - 1'b1;
  assign ui   = ui_q[UsedIdxW-1:0];
  assign fin  = fi_q < fcnt_q;

  logic [32:0] want_tot;
  assign want_tot = ({1'b0, request_bytes_i} + 33'(HdrBytes) + 33'd7) & ~{1'b0, AlignMask};

  logic [32:0] left;
  assign left = {1'b0, fsz_q[fi]} - total_q;

  logic prev_adj, next_adj;
  assign prev_adj = (fi_q != '0) && ({1'b0, fst_q[fim1]} + {1'b0, fsz_q[fim1]} == {1'b0, bs_q});
  assign next_adj = fin && ({1'b0, bs_q} + {1'b0, bz_q} == {1'b0, fst_q[fi]});

  always_comb begin
    sts_o = '0;
    sts_o.hold = cfg_we_i || init_q;
    sts_o.is_free = kind_q;
    sts_o.bad  = (total_q == '0) || total_q[32] || (total_q > {1'b0, rem_q});
    sts_o.fend = !fin;
    sts_o.fhit = fin && (kind_q ? (fst_q[fi] > bs_q) : ({1'b0, fsz_q[fi]} >= total_q));
    sts_o.uend = ui_q == UsedCntW'(MaxUsed);
    sts_o.uhit = !sts_o.uend && (kind_q ?
                 (uval_q[ui] && ({1'b0, ust_q[ui]} + 33'(HdrBytes) == {1'b0, addr_q}))
                 : !uval_q[ui]);
    sts_o.need_shift = kind_q ? ((prev_adj && next_adj) || (!prev_adj && !next_adj))
                              : !(left > 33'(2 * HdrBytes));
    sts_o.shift_done = ins_q ? (sh_q <= fi_q) : (sh_q + 1'b1 >= fcnt_q);
    sts_o.full = !prev_adj && !next_adj && (fcnt_q >= FreeCntW'(MaxFree));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ResetBase;
      bytes_q <= ResetBytes;
      init_q <= 1'b1;
      fcnt_q <= '0;
      uval_q <= '0;
      rem_q  <= '0;
    end else if (cfg_we_i && cfg_idx_ok_i) begin
      if (cfg_idx_i == CfgBase) base_q <= cfg_data_i;
      else bytes_q <= cfg_data_i;
      init_q <= 1'b1;
    end else if (init_q) begin
      init_q <= 1'b0;
      uval_q <= '0;
      fcnt_q <= a_ok ? FreeCntW'(1) : '0;
      rem_q  <= a_ok ? 32'(a_mark - a_start) : '0;
      fst_q[0] <= a_start[31:0];
      fsz_q[0] <= 32'(a_mark - a_start);
    end else begin
      if (cmd_i.start) begin
        kind_q  <= kind_i;
        total_q <= (request_bytes_i == '0) ? '0 : want_tot;
        addr_q  <= block_address_i;
        fi_q <= '0;
        ui_q <= '0;
        st_q <= StOk;
        gr_q <= '0;
      end
      if (state_i == S_LOOKUP && !kind_q && sts_o.bad) st_q <= StNoFit;
      if (cmd_i.fstep) begin
        if (kind_q) begin
          if (!sts_o.fhit && !sts_o.fend) fi_q <= fi_q + 1'b1;
        end else if (sts_o.fend) st_q <= StNoFit;
        else if (!sts_o.fhit) fi_q <= fi_q + 1'b1;
      end
      if (cmd_i.ustep) begin
        if (sts_o.uend) st_q <= kind_q ? StUnknown : StFull;
        else if (sts_o.uhit) begin
          if (kind_q) begin
            bs_q <= ust_q[ui];
            bz_q <= usz_q[ui];
          end
        end else ui_q <= ui_q + 1'b1;
      end
      if (cmd_i.acommit) begin
        uval_q[ui] <= 1'b1;
        ust_q[ui]  <= fst_q[fi];
        gr_q <= fst_q[fi] + 32'(HdrBytes);
        if (left > 33'(2 * HdrBytes)) begin
          usz_q[ui] <= total_q[31:0];
          fst_q[fi] <= fst_q[fi] + total_q[31:0];
          fsz_q[fi] <= left[31:0];
          rem_q <= rem_q - total_q[31:0];
        end else begin
          usz_q[ui] <= fsz_q[fi];
          rem_q <= rem_q - fsz_q[fi];
          ins_q <= 1'b0;
          sh_q  <= fi_q;
        end
      end
      if (cmd_i.fcommit) begin
        if (sts_o.full) st_q <= StFull;
        else begin
          uval_q[ui] <= 1'b0;
          rem_q <= rem_q + bz_q;
          if (prev_adj && next_adj) begin
            fsz_q[fim1] <= fsz_q[fim1] + bz_q + fsz_q[fi];
            ins_q <= 1'b0;
            sh_q  <= fi_q;
          end else if (prev_adj) fsz_q[fim1] <= fsz_q[fim1] + bz_q;
          else if (next_adj) begin
            fst_q[fi] <= bs_q;
            fsz_q[fi] <= fsz_q[fi] + bz_q;
          end else begin
            ins_q <= 1'b1;
            sh_q  <= fcnt_q;
          end
        end
      end
      if (cmd_i.shstep) begin
        if (ins_q) begin
          if (sh_q <= fi_q) begin
            fst_q[fi] <= bs_q;
            fsz_q[fi] <= bz_q;
            fcnt_q <= fcnt_q + 1'b1;
          end else begin
            fst_q[sh_q[FreeIdxW-1:0]] <= fst_q[FreeIdxW'(sh_q - 1'b1)];
            fsz_q[sh_q[FreeIdxW-1:0]] <= fsz_q[FreeIdxW'(sh_q - 1'b1)];
            sh_q <= sh_q - 1'b1;
          end
        end else if (sh_q + 1'b1 >= fcnt_q) fcnt_q <= fcnt_q - 1'b1;
        else begin
          fst_q[sh_q[FreeIdxW-1:0]] <= fst_q[FreeIdxW'(sh_q + 1'b1)];
          fsz_q[sh_q[FreeIdxW-1:0]] <= fsz_q[FreeIdxW'(sh_q + 1'b1)];
          sh_q <= sh_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        rsp_gr_q <= gr_q;
        rsp_st_q <= st_q;
        rsp_bf_q <= rem_q;
      end
    end
  end

  assign granted_address_o = rsp_gr_q;
  assign status_o          = rsp_st_q;
  assign bytes_free_o      = rsp_bf_q;
endmodule

[design/first_fit_heap_allocator.sv]
// First-fit heap allocator. Each request is answered with exactly one result. An
// allocate request walks the free table for the first segment that fits, then the used
// table for an empty slot, and commits, shifting the free table when it uses a segment up;
// a free request walks the used table for its block, then the free table for its
// neighbours, and commits, shifting the free table where a segment is inserted or removed.
// A rejected size is answered straight after the lookup, without a table walk. Both
// tables are walked sequentially, one entry at a time. A write to either region register
// rebuilds the tables in the following cycle; no request is taken in the write cycle
// or in that cycle.
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  ffha_req_if.sink    req,
  ffha_rsp_if.source  rsp
);
  cmd_t    cmd;
  status_t sts;
  state_e  state;
  logic    ready_int;

  ffha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (req.valid),
    .req_ready_o (ready_int),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  // The controller already holds ready low during a region write and the rebuild.
  assign req.ready = ready_int;

  ffha_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i,
    .cfg_idx_ok_i    (1'b1),
    .cfg_data_i,
    .kind_i          (req.kind),
    .request_bytes_i (req.request_bytes),
    .block_address_i (req.block_address),
    .cmd_i           (cmd),
    .state_i         (state),
    .sts_o           (sts),
    .granted_address_o (rsp.granted_address),
    .status_o          (rsp.status),
    .bytes_free_o      (rsp.bytes_free)
  );

  // A result is only produced from the finishing state.
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp.valid) |-> $past(state) == S_DONE)
    else $error("result raised outside finish");
  // Requests are not taken mid-walk.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> state == S_IDLE)
    else $error("ready while busy");
endmodule

[verif/testbench.sv]
module testbench;
  import ffha_pkg::*;

  // Result fields of one request, as the allocator should report them.
  typedef struct packed {
    logic [31:0] granted;
    logic [1:0]  status;
    logic [31:0] bytes_free;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req.sink),
    .rsp        (rsp.source)
  );

  // The predictor's own copy of the region registers and both tables.
  logic [31:0] region_base;
  logic [31:0] region_bytes;
  logic [31:0] seg_start [MaxFree];
  logic [31:0] seg_len   [MaxFree];
  int unsigned seg_cnt;
  logic [31:0] blk_start [MaxUsed];
  logic [31:0] blk_len   [MaxUsed];
  logic        blk_live  [MaxUsed];
  logic [31:0] avail_bytes;

  answer_t     pending_answers[$];
  logic [31:0] live_addrs[$];
  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned answers_seen;
  int unsigned cycle_count;
  int unsigned status_hits[4];
  bit          steady_traffic;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned SettleCycles = 100;

  // Rebuild the tables from the region registers: align the base up, reserve
  // the end marker below the (clamped) region end and align it down.
  function automatic void rebuild_heap();
    logic [32:0] lo;
    logic [32:0] hi;
    logic [32:0] marker;
    lo = ({1'b0, region_base} + 33'd7) & ~33'd7;
    hi = {1'b0, region_base} + {1'b0, region_bytes};
    if (hi > 33'h1_0000_0000) hi = 33'h1_0000_0000;
    for (int i = 0; i < MaxUsed; i++) blk_live[i] = 1'b0;
    for (int i = 0; i < MaxFree; i++) begin
      seg_start[i] = '0;
      seg_len[i] = '0;
    end
    seg_cnt = 0;
    avail_bytes = '0;
    if (hi >= lo + HdrBytes) begin
      marker = (hi - HdrBytes) & ~33'd7;
      if (marker > lo) begin
        seg_start[0] = lo[31:0];
        seg_len[0] = 32'(marker - lo);
        seg_cnt = 1;
        avail_bytes = seg_len[0];
      end
    end
  endfunction

  function automatic void drop_segment(int unsigned idx);
    for (int unsigned k = idx; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k + 1];
      seg_len[k] = seg_len[k + 1];
    end
    seg_cnt--;
  endfunction

  function automatic logic [1:0] carve_block(logic [31:0] want, output logic [31:0] granted);
    longint unsigned need;
    int unsigned     i;
    int unsigned     slot;
    logic [31:0]     at;
    logic [31:0]     len;
    granted = '0;
    if (want == 0) return StNoFit;
    need = (longint'(want) + HdrBytes + 7) & ~64'd7;
    if (need > 64'hFFFF_FFFF || need > avail_bytes) return StNoFit;
    for (i = 0; i < seg_cnt; i++)
      if (seg_len[i] >= need) break;
    if (i >= seg_cnt) return StNoFit;
    for (slot = 0; slot < MaxUsed; slot++)
      if (!blk_live[slot]) break;
    if (slot >= MaxUsed) return StFull;
    at = seg_start[i];
    // The remainder stays put in the table when the leftover is worth keeping.
    if (longint'(seg_len[i]) - need > 2 * HdrBytes) begin
      len = need[31:0];
      seg_start[i] = at + len;
      seg_len[i] -= len;
    end else begin
      len = seg_len[i];
      drop_segment(i);
    end
    avail_bytes -= len;
    blk_live[slot] = 1'b1;
    blk_start[slot] = at;
    blk_len[slot] = len;
    granted = at + HdrBytes;
    return StOk;
  endfunction

  function automatic logic [1:0] release_block(logic [31:0] addr);
    int unsigned     slot;
    int unsigned     p;
    longint unsigned s;
    longint unsigned sz;
    bit              joins_prev;
    bit              joins_next;
    for (slot = 0; slot < MaxUsed; slot++)
      if (blk_live[slot] && longint'(blk_start[slot]) + HdrBytes == longint'(addr)) break;
    if (slot >= MaxUsed) return StUnknown;
    s = blk_start[slot];
    sz = blk_len[slot];
    for (p = 0; p < seg_cnt; p++)
      if (seg_start[p] > s) break;
    joins_prev = p > 0 && longint'(seg_start[p - 1]) + seg_len[p - 1] == s;
    joins_next = p < seg_cnt && s + sz == seg_start[p];
    if (joins_prev && joins_next) begin
      seg_len[p - 1] = 32'(seg_len[p - 1] + sz + seg_len[p]);
      drop_segment(p);
    end else if (joins_prev) begin
      seg_len[p - 1] = 32'(seg_len[p - 1] + sz);
    end else if (joins_next) begin
      seg_start[p] = s[31:0];
      seg_len[p] = 32'(seg_len[p] + sz);
    end else begin
      if (seg_cnt >= MaxFree) return StFull;
      for (int unsigned k = seg_cnt; k > p; k--) begin
        seg_start[k] = seg_start[k - 1];
        seg_len[k] = seg_len[k - 1];
      end
      seg_start[p] = s[31:0];
      seg_len[p] = sz[31:0];
      seg_cnt++;
    end
    blk_live[slot] = 1'b0;
    avail_bytes = 32'(avail_bytes + sz);
    return StOk;
  endfunction

  // Works out the answer to one accepted request and keeps the list of live
  // user addresses up to date for the stimulus.
  function automatic answer_t predict_answer(logic kind, logic [31:0] want, logic [31:0] addr);
    answer_t a;
    a.granted = '0;
    if (!kind) begin
      a.status = carve_block(want, a.granted);
      if (a.status == StOk) live_addrs.push_back(a.granted);
    end else begin
      a.status = release_block(addr);
      if (a.status == StOk)
        foreach (live_addrs[i])
          if (live_addrs[i] == addr) begin
            live_addrs.delete(i);
            break;
          end
    end
    a.bytes_free = avail_bytes;
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH at answer %0d: %s is %h, expected %h", answers_seen, what, got, want);
  endtask

  // Mostly short gaps, now and then a long one; none during steady stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_traffic) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d answers outstanding.",
               cycle_count, pending_answers.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // The receiving side stalls at random, like the sending side.
  always @(negedge clk_i) begin
    if (rst_ni) rsp.ready <= (pick_gap() == 0);
  end

  // Every answer taken is compared field by field with the oldest prediction.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        $display("MISMATCH: answer %0d arrived with no request outstanding", answers_seen);
      end else begin
        want = pending_answers.pop_front();
        status_hits[rsp.status]++;
        if (rsp.granted_address !== want.granted)
          report_mismatch("granted_address", rsp.granted_address, want.granted);
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.bytes_free !== want.bytes_free)
          report_mismatch("bytes_free", rsp.bytes_free, want.bytes_free);
      end
    end
  end

  // Sends one request. The valid line is only lowered when a gap is wanted, so
  // that back-to-back requests never see valid dropped and raised in one step.
  task automatic send_request(logic kind, logic [31:0] want, logic [31:0] addr);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req.valid <= 1'b1;
    req.kind <= kind;
    req.request_bytes <= want;
    req.block_address <= addr;
    do @(posedge clk_i); while (!req.ready);
    pending_answers.push_back(predict_answer(kind, want, addr));
    requests_sent++;
  endtask

  task automatic send_alloc(logic [31:0] want);
    send_request(1'b0, want, $urandom());
  endtask

  task automatic send_free(logic [31:0] addr);
    send_request(1'b1, $urandom(), addr);
  endtask

  // Holds off until every outstanding answer has come back, then lets the
  // block finish any walk still in progress.
  task automatic drain_answers();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_region(logic [0:0] idx, logic [31:0] value);
    drain_answers();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgBase) region_base = value;
    else region_bytes = value;
    rebuild_heap();
    live_addrs.delete();
    repeat (2) @(negedge clk_i);
  endtask

  // Zero, oversized and unfittable sizes, an unknown free and a whole-heap grab
  // on the region left by reset.
  task automatic test_sizes_after_reset();
    logic [31:0] whole;
    send_alloc(32'd0);
    send_alloc(32'hFFFF_FFFF);
    send_alloc(32'hFFFF_FFF0);
    send_alloc(32'h2000_0000);
    send_free(32'd0);
    send_alloc(32'd1);
    send_free(live_addrs[0]);
    send_free(32'hFFFF_FFFF);
    whole = avail_bytes - HdrBytes;
    send_alloc(whole);
    send_alloc(32'd8);
    send_free(live_addrs[0]);
  endtask

  // Fills the used table, then fragments the free table until it is full.
  task automatic test_table_limits();
    logic [31:0] blocks[MaxUsed];
    for (int i = 0; i < MaxUsed; i++) begin
      send_alloc(32'd1);
      blocks[i] = live_addrs[live_addrs.size() - 1];
    end
    send_alloc(32'd1);
    for (int i = 0; i < MaxUsed - 2; i += 2) send_free(blocks[i]);
    // Every free entry is now taken, and this block touches none of them.
    send_free(blocks[MaxUsed - 2]);
    send_free(blocks[MaxUsed - 1]);
    send_free(blocks[MaxUsed - 2]);
    send_free(blocks[1]);
    send_free(blocks[1]);
  endtask

  // Regions that are too small, that wrap or that clamp at the top.
  task automatic test_region_edges();
    write_region(CfgBase, 32'hFFFF_FFF9);
    write_region(CfgBytes, 32'd64);
    send_alloc(32'd1);
    write_region(CfgBase, 32'd0);
    send_alloc(32'd8);
    send_alloc(32'd16);
    write_region(CfgBase, 32'd3);
    write_region(CfgBytes, 32'hFFFF_FFFF);
    send_alloc(32'h8000_0000);
    send_alloc(32'h8000_0000);
    write_region(CfgBase, 32'hFFFF_FF00);
    send_alloc(32'd100);
    send_alloc(32'd100);
    write_region(CfgBase, 32'hFFFF_FFFF);
    send_alloc(32'd1);
  endtask

  // Mostly well-formed traffic on small heaps: allocations of modest size and
  // frees of live blocks, with random and misplaced frees mixed in.
  task automatic test_random_traffic(int unsigned count);
    int unsigned r;
    logic [31:0] pick;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 170 == 0) begin
        write_region(CfgBase, ($urandom_range(3) == 0) ? $urandom() : $urandom_range(4095));
        write_region(CfgBytes, $urandom_range(8192, 64));
      end
      if (n % 60 == 0) steady_traffic = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < 50) begin
        send_alloc(($urandom_range(9) == 0) ? $urandom() : $urandom_range(700, 1));
      end else if (r < 90 && live_addrs.size() != 0) begin
        send_free(live_addrs[$urandom_range(live_addrs.size() - 1)]);
      end else if (r < 95) begin
        send_free($urandom());
      end else begin
        pick = (live_addrs.size() != 0) ? live_addrs[0] + 8 : 32'd0;
        send_free(pick);
      end
    end
    steady_traffic = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgBase;
    cfg_data_i = '0;
    req.valid = 1'b0;
    req.kind = 1'b0;
    req.request_bytes = '0;
    req.block_address = '0;
    rsp.ready = 1'b0;
    steady_traffic = 1'b0;
    region_base = ResetBase;
    region_bytes = ResetBytes;
    rebuild_heap();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_sizes_after_reset();
    test_table_limits();
    test_region_edges();
    test_random_traffic(800);

    drain_answers();
    $display("Sent %0d requests and checked %0d answers over several heap regions.",
             requests_sent, answers_seen);
    $display("Status counts: ok %0d, no fit %0d, unknown %0d, full %0d.",
             status_hits[StOk], status_hits[StNoFit], status_hits[StUnknown],
             status_hits[StFull]);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[first_fit_heap_allocator.f]
design/ffha_pkg.sv
design/ffha_if.sv
design/ffha_ctrl.sv
design/ffha_dp.sv
design/first_fit_heap_allocator.sv
verif/testbench.sv
